@@ hw/rtl/rnl_pkg.sv @@
// Package for the route and neighbor lookup engine.
// Holds table sizes, field codes, route entry and memory request types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rnl_pkg;

    localparam int ROUTE_DEPTH    = 1024;
    localparam int NEIGHBOR_DEPTH = 16;

    localparam int ROUTE_AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
    localparam int RCNT_W   = $clog2(ROUTE_DEPTH + 1);
    localparam int NBR_AW   = (NEIGHBOR_DEPTH > 1) ? $clog2(NEIGHBOR_DEPTH) : 1;
    localparam int NCNT_W   = $clog2(NEIGHBOR_DEPTH + 1);

    localparam int CFG_COUNT_W = 11;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic CFG_REG_ROUTE_COUNT = 1'b0;

    localparam logic [1:0] MODE_ROUTE_WR = 2'd0;
    localparam logic [1:0] MODE_NBR_ADD  = 2'd1;
    localparam logic [1:0] MODE_LOOKUP   = 2'd2;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_NO_ROUTE    = 3'd1;
    localparam logic [2:0] STATUS_MAC_UNKNOWN = 3'd2;
    localparam logic [2:0] STATUS_WRITE_DONE  = 3'd3;
    localparam logic [2:0] STATUS_TABLE_FULL  = 3'd4;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [7:0]  port;
    } route_entry_t;

    typedef struct packed {
        logic                wr_en;
        logic [ROUTE_AW-1:0] wr_addr;
        logic                rd_en;
        logic [ROUTE_AW-1:0] rd_addr;
    } rmem_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  port;
        logic [31:0] hop;
        logic [47:0] mac;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RSCAN,
        S_NSCAN,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/rnl_req_if.sv @@
// Request channel interface of the lookup engine.
// Carries valid, ready and one input item. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rnl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [9:0]  index;
    logic [31:0] address;
    logic [31:0] net_mask;
    logic [31:0] hop_address;
    logic [7:0]  port;
    logic [47:0] mac;

    modport source (
        output valid, mode, index, address, net_mask, hop_address, port, mac,
        input  ready
    );

    modport sink (
        input  valid, mode, index, address, net_mask, hop_address, port, mac,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/rnl_rsp_if.sv @@
// Response channel interface of the lookup engine.
// Carries valid, ready and one result item. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rnl_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  out_port;
    logic [31:0] out_hop;
    logic [47:0] out_mac;

    modport source (
        output valid, status, out_port, out_hop, out_mac,
        input  ready
    );

    modport sink (
        input  valid, status, out_port, out_hop, out_mac,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/rnl_route_mem.sv @@
// Route table memory: one write port and one registered read port.
// Depends on rnl_pkg for the entry type and the table depth.
`timescale 1ns / 1ps
`default_nettype none

module rnl_route_mem (
    input  wire logic                  clk,
    input  wire rnl_pkg::rmem_req_t    req,
    input  wire rnl_pkg::route_entry_t wr_data,
    output rnl_pkg::route_entry_t      rd_data
);

    rnl_pkg::route_entry_t mem [rnl_pkg::ROUTE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/route_and_neighbor_lookup_top.sv @@
// Top level of the IPv4 route and neighbor lookup engine.
// Depends on rnl_pkg, rnl_req_if, rnl_rsp_if and rnl_route_mem.
//
//   Channel  Direction  Handshake              Contents
//   req      in         valid/ready            mode, index, address, net_mask,
//                                              hop_address, port, mac
//   rsp      out        valid/ready            status, out_port, out_hop, out_mac
//   apb      in         psel/penable/pready    route_count at byte address 0
//
// A route write, a neighbor append or an unused mode goes from accept to S_RESULT, and the
// block is ready again in the same cycle that its result is loaded into the output register.
// A lookup scans n = min(route_count, 1024) route slots through the registered read port, then
// scans the neighbor slots from slot zero until one matches the hop or the neighbor count is
// reached; the neighbor scan is skipped when no route matches. Then the result is loaded.
// Reset clears the counts and the control state; table contents are undefined.
// The block takes no item from accept until its result is in the output register.
`timescale 1ns / 1ps
`default_nettype none

module route_and_neighbor_lookup_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    rnl_req_if.sink                           req,
    rnl_rsp_if.source                         rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rnl_pkg::APB_AW-1:0]   paddr,
    input  wire logic [rnl_pkg::APB_DW-1:0]   pwdata,
    output logic      [rnl_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    rnl_pkg::state_t state_reg;
    rnl_pkg::state_t state_next;

    logic [rnl_pkg::CFG_COUNT_W-1:0] route_count_reg;
    logic [rnl_pkg::NCNT_W-1:0]      nbr_count_reg;
    logic [rnl_pkg::RCNT_W-1:0]      limit_reg;
    logic [rnl_pkg::RCNT_W-1:0]      issue_reg;
    logic                            dvalid_reg;
    logic                            found_reg;
    logic [rnl_pkg::NCNT_W-1:0]      nidx_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic [31:0]          dest_reg;
    logic [31:0]          best_mask_reg;
    logic [31:0]          best_hop_reg;
    logic [7:0]           best_port_reg;
    rnl_pkg::result_t     res_reg;
    rnl_pkg::result_t     res_next;
    rnl_pkg::result_t     out_res_reg;

    logic [31:0] nbr_ip_mem  [rnl_pkg::NEIGHBOR_DEPTH];
    logic [47:0] nbr_mac_mem [rnl_pkg::NEIGHBOR_DEPTH];

    rnl_pkg::rmem_req_t    mem_req;
    rnl_pkg::route_entry_t mem_wr_data;
    rnl_pkg::route_entry_t mem_rd_data;

    logic                            accept;
    logic                            issue;
    logic                            scan_done;
    logic                            route_match;
    logic                            route_better;
    logic                            nbr_live;
    logic                            nbr_hit;
    logic                            nbr_full;
    logic                            out_load;
    logic                            cfg_wr;
    logic [rnl_pkg::RCNT_W-1:0]      limit_next;
    logic [rnl_pkg::NBR_AW-1:0]      nidx_addr;
    logic [rnl_pkg::NBR_AW-1:0]      nbr_wr_addr;

    rnl_route_mem u_route_mem (
        .clk     (clk),
        .req     (mem_req),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    assign nidx_addr   = nidx_reg[rnl_pkg::NBR_AW-1:0];
    assign nbr_wr_addr = nbr_count_reg[rnl_pkg::NBR_AW-1:0];
    assign nbr_full    = (32'(nbr_count_reg) >= rnl_pkg::NEIGHBOR_DEPTH);
    assign nbr_live    = (nidx_reg < nbr_count_reg);
    assign nbr_hit     = (nbr_ip_mem[nidx_addr] == best_hop_reg);
    assign limit_next  = (32'(route_count_reg) > rnl_pkg::ROUTE_DEPTH) ?
                         rnl_pkg::RCNT_W'(rnl_pkg::ROUTE_DEPTH) :
                         rnl_pkg::RCNT_W'(route_count_reg);

    // Shared compare unit used for every route slot of a scan.
    assign route_match  = ((mem_rd_data.prefix & mem_rd_data.mask) ==
                           (dest_reg & mem_rd_data.mask));
    assign route_better = !found_reg || (mem_rd_data.mask > best_mask_reg);

    assign mem_wr_data.prefix = req.address;
    assign mem_wr_data.mask   = req.net_mask;
    assign mem_wr_data.hop    = req.hop_address;
    assign mem_wr_data.port   = req.port;

    always_comb
    begin
        pready          = 1'b1;
        req.ready       = (state_reg == rnl_pkg::S_IDLE);
        accept          = req.valid && req.ready;
        issue           = (state_reg == rnl_pkg::S_RSCAN) && (issue_reg < limit_reg);
        scan_done       = (state_reg == rnl_pkg::S_RSCAN) && !issue && !dvalid_reg;
        out_load        = (state_reg == rnl_pkg::S_RESULT) && (!out_valid_reg || rsp.ready);
        mem_req.wr_en   = accept && (req.mode == rnl_pkg::MODE_ROUTE_WR) &&
                          (32'(req.index) < rnl_pkg::ROUTE_DEPTH);
        mem_req.wr_addr = rnl_pkg::ROUTE_AW'(req.index);
        mem_req.rd_en   = issue;
        mem_req.rd_addr = issue_reg[rnl_pkg::ROUTE_AW-1:0];
        cfg_wr          = psel && penable && pwrite && pready;
        prdata          = (paddr[2] == rnl_pkg::CFG_REG_ROUTE_COUNT) ?
                          rnl_pkg::APB_DW'(route_count_reg) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rnl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.mode == rnl_pkg::MODE_LOOKUP) ?
                                 rnl_pkg::S_RSCAN : rnl_pkg::S_RESULT;
                end
            end
            rnl_pkg::S_RSCAN:
            begin
                if (scan_done)
                begin
                    state_next = found_reg ? rnl_pkg::S_NSCAN : rnl_pkg::S_RESULT;
                end
            end
            rnl_pkg::S_NSCAN:
            begin
                if (!nbr_live || nbr_hit)
                begin
                    state_next = rnl_pkg::S_RESULT;
                end
            end
            rnl_pkg::S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = rnl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rnl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_next = res_reg;
        priority if (accept)
        begin
            res_next.status = (req.mode == rnl_pkg::MODE_NBR_ADD && nbr_full) ?
                              rnl_pkg::STATUS_TABLE_FULL : rnl_pkg::STATUS_WRITE_DONE;
            res_next.port   = '0;
            res_next.hop    = '0;
            res_next.mac    = '0;
        end
        else if (scan_done && !found_reg)
        begin
            res_next.status = rnl_pkg::STATUS_NO_ROUTE;
            res_next.port   = '0;
            res_next.hop    = '0;
            res_next.mac    = '0;
        end
        else if (state_reg == rnl_pkg::S_NSCAN)
        begin
            res_next.port = best_port_reg;
            res_next.hop  = best_hop_reg;
            if (nbr_live && nbr_hit)
            begin
                res_next.status = rnl_pkg::STATUS_OK;
                res_next.mac    = nbr_mac_mem[nidx_addr];
            end
            else
            begin
                res_next.status = rnl_pkg::STATUS_MAC_UNKNOWN;
                res_next.mac    = '0;
            end
        end
        else
        begin
            res_next = res_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rnl_pkg::S_IDLE;
            route_count_reg <= '0;
            nbr_count_reg   <= '0;
            limit_reg       <= '0;
            issue_reg       <= '0;
            dvalid_reg      <= 1'b0;
            found_reg       <= 1'b0;
            nidx_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dvalid_reg    <= issue;
            if (cfg_wr && paddr[2] == rnl_pkg::CFG_REG_ROUTE_COUNT)
            begin
                route_count_reg <= pwdata[rnl_pkg::CFG_COUNT_W-1:0];
            end
            if (accept)
            begin
                limit_reg <= limit_next;
                issue_reg <= '0;
                found_reg <= 1'b0;
                nidx_reg  <= '0;
                if (req.mode == rnl_pkg::MODE_NBR_ADD && !nbr_full)
                begin
                    nbr_count_reg <= nbr_count_reg + 1'b1;
                end
            end
            if (issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (dvalid_reg && route_match && route_better)
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == rnl_pkg::S_NSCAN && nbr_live && !nbr_hit)
            begin
                nidx_reg <= nidx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            dest_reg <= req.address;
            if (req.mode == rnl_pkg::MODE_NBR_ADD && !nbr_full)
            begin
                nbr_ip_mem[nbr_wr_addr]  <= req.address;
                nbr_mac_mem[nbr_wr_addr] <= req.mac;
            end
        end
        if (dvalid_reg && route_match && route_better)
        begin
            best_mask_reg <= mem_rd_data.mask;
            best_hop_reg  <= mem_rd_data.hop;
            best_port_reg <= mem_rd_data.port;
        end
        if (out_load)
        begin
            out_res_reg <= res_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_res_reg.status;
    assign rsp.out_port = out_res_reg.port;
    assign rsp.out_hop  = out_res_reg.hop;
    assign rsp.out_mac  = out_res_reg.mac;

endmodule

`default_nettype wire
